// ===== rtl/rgba_source_over_blend_assert.svh =====
// assertion macros for the source-over blender checks
`ifndef RGBA_SOURCE_OVER_BLEND_ASSERT_SVH
`define RGBA_SOURCE_OVER_BLEND_ASSERT_SVH

// same-cycle implication
`define RSOB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RSOB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rsob_pkg.sv =====
// types and constants shared by the source-over blender
package rsob_pkg;

	localparam int CH_N   = 3;
	localparam int PROD_W = 16;
	localparam int NUM_W  = 24;
	localparam int DEN_W  = 16;
	localparam int QUO_W  = 9;
	localparam int CELL_N = QUO_W;

	localparam logic [7:0]        FULL_ALPHA = 8'd255;
	localparam logic [PROD_W-1:0] ROUND_HALF = 16'd127;

	typedef struct packed {
		logic [7:0] src_red;
		logic [7:0] src_green;
		logic [7:0] src_blue;
		logic [7:0] src_alpha;
		logic [7:0] dst_red;
		logic [7:0] dst_green;
		logic [7:0] dst_blue;
		logic [7:0] dst_alpha;
		logic       frame_last;
	} pixel_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
		logic       frame_last_out;
	} blend_t;

	typedef struct packed {
		logic       pass;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last;
	} side_t;

	typedef struct packed {
		logic [CH_N-1:0][NUM_W-1:0] rem;
		logic [CH_N-1:0][QUO_W-1:0] quo;
		logic [NUM_W-1:0]           dvs;
		side_t                      side;
	} lane_t;

endpackage

// ===== rtl/rsob_front.sv =====
// product, alpha and divisor stages ahead of the divider chain
module rsob_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            feed_valid,
	input  rsob_pkg::pixel_t feed,
	output logic            lane_valid,
	output rsob_pkg::lane_t lane
);
	import rsob_pkg::*;

	logic                        valid_s1, valid_s2, valid_s3;
	logic [CH_N-1:0][7:0]        src_ch, dst_ch;
	logic [7:0]                  inv_c;
	side_t                       side_c;
	logic [CH_N-1:0][PROD_W-1:0] src_prod_s1, dst_prod_s1;
	logic [7:0]                  inv_s1;
	logic [PROD_W-1:0]           cov_s1;
	side_t                       side_s1;
	logic [PROD_W:0]             oa_sum;
	side_t                       side_c2;
	logic [CH_N-1:0][NUM_W-1:0]  num_s2;
	side_t                       side_s2;
	logic [DEN_W-1:0]            denom;
	lane_t                       lane_s3;

	assign src_ch = {feed.src_blue, feed.src_green, feed.src_red};
	assign dst_ch = {feed.dst_blue, feed.dst_green, feed.dst_red};
	assign inv_c  = FULL_ALPHA - feed.src_alpha;

	// opaque source copies the source, transparent source keeps the destination
	always_comb begin
		side_c.last = feed.frame_last;
		side_c.pass = (feed.src_alpha == FULL_ALPHA) || (feed.src_alpha == 8'd0);
		if (feed.src_alpha == FULL_ALPHA) begin
			side_c.red   = feed.src_red;
			side_c.green = feed.src_green;
			side_c.blue  = feed.src_blue;
			side_c.alpha = feed.src_alpha;
		end else begin
			side_c.red   = feed.dst_red;
			side_c.green = feed.dst_green;
			side_c.blue  = feed.dst_blue;
			side_c.alpha = feed.dst_alpha;
		end
	end

	// floor division by 255 of the rounded coverage
	assign oa_sum = {1'b0, cov_s1} + (PROD_W+1)'(cov_s1[15:8]) + 17'd1;

	always_comb begin
		side_c2 = side_s1;
		if (!side_s1.pass) begin
			side_c2.alpha = oa_sum[15:8];
		end
	end

	assign denom = {side_s2.alpha, 8'd0} - {8'd0, side_s2.alpha};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= feed_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < CH_N; c++) begin
				src_prod_s1[c] <= PROD_W'(src_ch[c]) * PROD_W'(feed.src_alpha);
				dst_prod_s1[c] <= PROD_W'(dst_ch[c]) * PROD_W'(feed.dst_alpha);
				num_s2[c]      <= ({src_prod_s1[c], 8'd0} - {8'd0, src_prod_s1[c]})
					+ NUM_W'(dst_prod_s1[c]) * NUM_W'(inv_s1);
				lane_s3.rem[c] <= num_s2[c] + NUM_W'(denom[DEN_W-1:1]);
			end
			inv_s1  <= inv_c;
			cov_s1  <= ({feed.src_alpha, 8'd0} - {8'd0, feed.src_alpha})
				+ PROD_W'(feed.dst_alpha) * PROD_W'(inv_c) + ROUND_HALF;
			side_s1 <= side_c;
			side_s2 <= side_c2;
			lane_s3.quo  <= '0;
			lane_s3.dvs  <= {denom, 8'd0};
			lane_s3.side <= side_s2;
		end
	end

	assign lane_valid = valid_s3;
	assign lane       = lane_s3;

endmodule

// ===== rtl/rsob_cell.sv =====
// one divider cell: a quotient bit per channel, then the divisor moves down a place
module rsob_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            up_valid,
	input  rsob_pkg::lane_t up,
	output logic            dn_valid,
	output rsob_pkg::lane_t dn
);
	import rsob_pkg::*;

	lane_t step;
	logic  valid_q;
	lane_t lane_q;

	always_comb begin
		step     = up;
		step.dvs = up.dvs >> 1;
		for (int c = 0; c < CH_N; c++) begin
			if (up.rem[c] >= up.dvs) begin
				step.rem[c] = up.rem[c] - up.dvs;
				step.quo[c] = {up.quo[c][QUO_W-2:0], 1'b1};
			end else begin
				step.quo[c] = {up.quo[c][QUO_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_q <= step;
		end
	end

	assign dn_valid = valid_q;
	assign dn       = lane_q;

endmodule

// ===== rtl/rgba_source_over_blend.sv =====
// a pixel passes the front stages, the nine divider cells and the output register; stalls hold it
// throughput: one pixel per unstalled cycle, nine divider cells each settling one quotient bit
// the whole pipeline freezes while a finished pixel waits at the output
// reset clears the valid flags and the input skid; payload registers are not reset
// top level of the rounded source-over blender
module rgba_source_over_blend (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pixel_valid,
	output logic             pixel_stall,
	input  rsob_pkg::pixel_t pixel,
	output logic             blend_valid,
	input  logic             blend_stall,
	output rsob_pkg::blend_t blend
);
	import rsob_pkg::*;

	logic                 en;
	logic                 skid_valid_q;
	pixel_t               skid_q;
	logic                 in_take;
	logic                 feed_valid;
	pixel_t               feed;
	logic [CELL_N:0]      cell_valid;
	lane_t                cell_lane [CELL_N+1];
	logic [CH_N-1:0][7:0] ch_c;
	blend_t               res_c;
	logic                 blend_valid_q;
	blend_t               blend_q;

	assign en          = !(blend_valid_q && blend_stall);
	assign pixel_stall = skid_valid_q;
	assign in_take     = pixel_valid && !skid_valid_q;
	assign feed_valid  = skid_valid_q || pixel_valid;
	assign feed        = skid_valid_q ? skid_q : pixel;

	// skid holds one transfer taken while the pipeline is frozen
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (en) begin
			skid_valid_q <= 1'b0;
		end else if (in_take) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && in_take) begin
			skid_q <= pixel;
		end
	end

	rsob_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.feed_valid(feed_valid),
		.feed      (feed),
		.lane_valid(cell_valid[0]),
		.lane      (cell_lane[0])
	);

	for (genvar i = 0; i < CELL_N; i++) begin : g_cell
		rsob_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.up_valid(cell_valid[i]),
			.up      (cell_lane[i]),
			.dn_valid(cell_valid[i+1]),
			.dn      (cell_lane[i+1])
		);
	end

	// quotient of 256 and above saturates
	always_comb begin
		for (int c = 0; c < CH_N; c++) begin
			if (cell_lane[CELL_N].quo[c][QUO_W-1]) begin
				ch_c[c] = FULL_ALPHA;
			end else begin
				ch_c[c] = cell_lane[CELL_N].quo[c][7:0];
			end
		end
		if (cell_lane[CELL_N].side.pass) begin
			res_c.out_red   = cell_lane[CELL_N].side.red;
			res_c.out_green = cell_lane[CELL_N].side.green;
			res_c.out_blue  = cell_lane[CELL_N].side.blue;
		end else begin
			res_c.out_red   = ch_c[0];
			res_c.out_green = ch_c[1];
			res_c.out_blue  = ch_c[2];
		end
		res_c.out_alpha      = cell_lane[CELL_N].side.alpha;
		res_c.frame_last_out = cell_lane[CELL_N].side.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_valid_q <= 1'b0;
		end else if (en) begin
			blend_valid_q <= cell_valid[CELL_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			blend_q <= res_c;
		end
	end

	assign blend_valid = blend_valid_q;
	assign blend       = blend_q;

endmodule

// ===== rtl/rsob_checker.sv =====
// port-level checks for the source-over blender and their binding
`include "rgba_source_over_blend_assert.svh"

module rsob_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             pixel_valid,
	input logic             pixel_stall,
	input logic             blend_valid,
	input logic             blend_stall,
	input rsob_pkg::blend_t blend
);

	`RSOB_ASSERT_NEXT(a_out_hold, blend_valid && blend_stall, blend_valid && $stable(blend), "stalled result changed")
	`RSOB_ASSERT_NOW(a_skid_fill, $rose(pixel_stall), $past(pixel_valid && blend_valid && blend_stall), "input stall without output stall")
	`RSOB_ASSERT_NEXT(a_skid_drain, !blend_stall, !pixel_stall, "skid not drained while output free")

endmodule

bind rgba_source_over_blend rsob_checker u_rsob_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.pixel_valid(pixel_valid),
	.pixel_stall(pixel_stall),
	.blend_valid(blend_valid),
	.blend_stall(blend_stall),
	.blend      (blend)
);

// ===== tb/rgba_source_over_blend_test.sv =====
// self-checking stream test of the source-over blender against its own pixel predictor
`timescale 1ns / 1ps

module rgba_source_over_blend_test;

	import rsob_pkg::*;

	localparam int unsigned OPAQUE      = FULL_ALPHA;
	localparam int unsigned ROUND_ALPHA = ROUND_HALF;
	localparam int          RAND_PIXELS = 1150;
	localparam int          QUIET_FROM  = 400;
	localparam int          QUIET_TO    = 1000;
	localparam int          CYCLE_LIMIT = 100000;
	localparam int          DRAIN_CYCLES = 40;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   pixel_valid = 1'b0;
	logic   pixel_stall;
	pixel_t pixel = '0;
	logic   blend_valid;
	logic   blend_stall = 1'b0;
	blend_t blend;

	pixel_t pending_pixels[$];
	blend_t composites_due[$];

	int cycle_count = 0;
	int error_count = 0;
	int sent_count = 0;
	int checked_count = 0;
	int transparent_count = 0;
	int opaque_count = 0;
	int clamp_count = 0;
	int framed_count = 0;

	rgba_source_over_blend dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel),
		.blend_valid (blend_valid),
		.blend_stall (blend_stall),
		.blend       (blend)
	);

	always #1 clk = ~clk;

	function automatic blend_t composite_pixel(input pixel_t p, output bit clamped);
		blend_t      r;
		int unsigned sa, da, oa, den, num, q;
		int unsigned s[3];
		int unsigned d[3];
		logic [7:0]  ch[3];
		sa = p.src_alpha;
		da = p.dst_alpha;
		s[0] = p.src_red;
		s[1] = p.src_green;
		s[2] = p.src_blue;
		d[0] = p.dst_red;
		d[1] = p.dst_green;
		d[2] = p.dst_blue;
		clamped = 1'b0;
		r.frame_last_out = p.frame_last;
		oa = 0;
		if (sa != 0)
			oa = (sa * OPAQUE + da * (OPAQUE - sa) + ROUND_ALPHA) / OPAQUE;
		if (sa == OPAQUE) begin
			r.out_red   = p.src_red;
			r.out_green = p.src_green;
			r.out_blue  = p.src_blue;
			r.out_alpha = p.src_alpha;
		end else if (oa == 0) begin
			r.out_red   = p.dst_red;
			r.out_green = p.dst_green;
			r.out_blue  = p.dst_blue;
			r.out_alpha = p.dst_alpha;
		end else begin
			den = OPAQUE * oa;
			for (int i = 0; i < 3; i++) begin
				num = s[i] * sa * OPAQUE + d[i] * da * (OPAQUE - sa);
				q = (num + den / 2) / den;
				if (q > OPAQUE) begin
					q = OPAQUE;
					clamped = 1'b1;
				end
				ch[i] = q[7:0];
			end
			r.out_red   = ch[0];
			r.out_green = ch[1];
			r.out_blue  = ch[2];
			r.out_alpha = oa[7:0];
		end
		return r;
	endfunction

	task automatic queue_pixel(input logic [7:0] sr, sg, sb, sa, dr, dg, db, da,
			input logic last);
		pixel_t p;
		p.src_red    = sr;
		p.src_green  = sg;
		p.src_blue   = sb;
		p.src_alpha  = sa;
		p.dst_red    = dr;
		p.dst_green  = dg;
		p.dst_blue   = db;
		p.dst_alpha  = da;
		p.frame_last = last;
		pending_pixels = {pending_pixels, p};
	endtask

	function automatic logic [7:0] pick_alpha();
		int unsigned r;
		r = $urandom_range(0, 9);
		case (r)
			0: return 8'd0;
			1: return 8'd255;
			2, 3: return 8'($urandom_range(1, 40));
			4: return 8'($urandom_range(250, 254));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] pick_colour();
		int unsigned r;
		r = $urandom_range(0, 7);
		case (r)
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic bit quiet_stretch();
		return cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			error_count++;
		end
	endtask

	// driver: next pixel once the previous one has gone or none is up
	always @(posedge clk) begin
		bit     clamped;
		blend_t due;
		if (!arst_n) begin
			pixel_valid <= 1'b0;
		end else if (!pixel_valid || !pixel_stall) begin
			if (pixel_valid) begin
				due = composite_pixel(pixel, clamped);
				composites_due = {composites_due, due};
				sent_count++;
				if (pixel.src_alpha == 8'd0)
					transparent_count++;
				if (pixel.src_alpha == FULL_ALPHA)
					opaque_count++;
				if (clamped)
					clamp_count++;
				if (pixel.frame_last)
					framed_count++;
			end
			if (pending_pixels.size() != 0 &&
					(quiet_stretch() || $urandom_range(0, 99) >= 28)) begin
				pixel       <= pending_pixels.pop_front();
				pixel_valid <= 1'b1;
			end else begin
				pixel_valid <= 1'b0;
			end
		end
	end

	// monitor: check each output transfer, stall at random outside the quiet stretch
	always @(posedge clk) begin
		blend_t want;
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d composites outstanding", $time, composites_due.size());
			$display("CHECKS FAILED");
			$finish;
		end else if (!arst_n) begin
			blend_stall <= 1'b0;
		end else begin
			if (blend_valid && !blend_stall) begin
				if (composites_due.size() == 0) begin
					$display("%0t: unexpected transfer, expected none got %h", $time, blend);
					error_count++;
				end else begin
					want = composites_due.pop_front();
					check_field("out_red", want.out_red, blend.out_red);
					check_field("out_green", want.out_green, blend.out_green);
					check_field("out_blue", want.out_blue, blend.out_blue);
					check_field("out_alpha", want.out_alpha, blend.out_alpha);
					check_field("frame_last_out", want.frame_last_out, blend.frame_last_out);
					checked_count++;
				end
			end
			blend_stall <= !quiet_stretch() && $urandom_range(0, 99) < 28;
		end
	end

	initial begin
		logic [7:0] sa, da;
		int         total;
		queue_pixel(8'd10, 8'd20, 8'd30, 8'd0, 8'd200, 8'd100, 8'd50, 8'd77, 1'b0);
		queue_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		queue_pixel(8'd1, 8'd2, 8'd3, 8'd255, 8'd9, 8'd9, 8'd9, 8'd9, 1'b1);
		queue_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
		queue_pixel(8'd255, 8'd128, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		queue_pixel(8'd255, 8'd0, 8'd255, 8'd254, 8'd0, 8'd255, 8'd0, 8'd255, 1'b1);
		queue_pixel(8'd200, 8'd100, 8'd50, 8'd128, 8'd50, 8'd100, 8'd200, 8'd128, 1'b0);
		queue_pixel(8'd255, 8'd255, 8'd255, 8'd254, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
		queue_pixel(8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd255, 1'b0);
		queue_pixel(8'd0, 8'd0, 8'd0, 8'd254, 8'd255, 8'd255, 8'd255, 8'd0, 1'b0);
		// alpha pairs whose channel quotient reaches 255 or overshoots it
		queue_pixel(8'd255, 8'd255, 8'd255, 8'd12, 8'd255, 8'd255, 8'd255, 8'd12, 1'b0);
		queue_pixel(8'd255, 8'd255, 8'd255, 8'd10, 8'd255, 8'd255, 8'd255, 8'd20, 1'b1);
		queue_pixel(8'd255, 8'd255, 8'd255, 8'd3, 8'd255, 8'd255, 8'd255, 8'd60, 1'b0);
		queue_pixel(8'd255, 8'd255, 8'd255, 8'd1, 8'd255, 8'd255, 8'd255, 8'd200, 1'b0);
		queue_pixel(8'd17, 8'd240, 8'd99, 8'd127, 8'd3, 8'd250, 8'd128, 8'd255, 1'b0);
		queue_pixel(8'd255, 8'd0, 8'd255, 8'd1, 8'd0, 8'd255, 8'd0, 8'd1, 1'b0);
		queue_pixel(8'h55, 8'haa, 8'h55, 8'haa, 8'haa, 8'h55, 8'haa, 8'h55, 1'b1);
		queue_pixel(8'haa, 8'h55, 8'haa, 8'h55, 8'h55, 8'haa, 8'h55, 8'haa, 1'b0);
		for (int n = 0; n < RAND_PIXELS; n++) begin
			sa = pick_alpha();
			da = pick_alpha();
			if ($urandom_range(0, 7) == 0)
				// white on white with faint alphas pushes the channel towards overshoot
				queue_pixel(8'd255, 8'd255, 8'd255, 8'($urandom_range(1, 60)),
					8'd255, 8'd255, 8'd255, 8'($urandom_range(1, 120)),
					$urandom_range(0, 15) == 0);
			else
				queue_pixel(pick_colour(), pick_colour(), pick_colour(), sa,
					pick_colour(), pick_colour(), pick_colour(), da,
					$urandom_range(0, 15) == 0);
		end
		total = pending_pixels.size();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (checked_count < total)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d pixels, checked %0d composites", sent_count, checked_count);
		$display("transparent %0d, opaque %0d, saturated %0d, frame ends %0d",
			transparent_count, opaque_count, clamp_count, framed_count);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rsob_pkg.sv
rtl/rsob_front.sv
rtl/rsob_cell.sv
rtl/rgba_source_over_blend.sv
rtl/rsob_checker.sv
tb/rgba_source_over_blend_test.sv
